FILE: rtl/core/assert_macros.svh
// assertion macros used by the core top level
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define PAC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/pacac_pkg.sv
// shared types, codes and constants of the pin and card access controller core
// no dependencies
`default_nettype none

package pacac_pkg;

    localparam int CODE_DIGITS = 4;
    localparam int CNT_W       = $clog2(CODE_DIGITS + 1);

    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_CARD = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_LOCK = 2'd2;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_DIGIT      = 4'd1;
    localparam logic [3:0] EV_CLEARED    = 4'd2;
    localparam logic [3:0] EV_CODE_OK    = 4'd3;
    localparam logic [3:0] EV_CODE_BAD   = 4'd4;
    localparam logic [3:0] EV_CARD_OK    = 4'd5;
    localparam logic [3:0] EV_CARD_BAD   = 4'd6;
    localparam logic [3:0] EV_GRANTED    = 4'd7;
    localparam logic [3:0] EV_LOCK_START = 4'd8;
    localparam logic [3:0] EV_LOCK_END   = 4'd9;
    localparam logic [3:0] EV_RELOCKED   = 4'd10;
    localparam logic [3:0] EV_IGNORED    = 4'd11;

    localparam logic [2:0] REG_STORED_CODE    = 3'd0;
    localparam logic [2:0] REG_STORED_CARD    = 3'd1;
    localparam logic [2:0] REG_ATTEMPT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_LOCKOUT_LENGTH = 3'd3;
    localparam logic [2:0] REG_OPEN_LENGTH    = 3'd4;

    localparam logic [15:0] RST_STORED_CODE    = 16'h1234;
    localparam logic [39:0] RST_STORED_CARD    = 40'hA1B2C3D4E5;
    localparam logic [3:0]  RST_ATTEMPT_LIMIT  = 4'd3;
    localparam logic [15:0] RST_LOCKOUT_LENGTH = 16'd30000;
    localparam logic [15:0] RST_OPEN_LENGTH    = 16'd2000;

    localparam logic [3:0] FAIL_MAX = 4'hF;

    typedef struct packed {
        logic [15:0] stored_code;
        logic [39:0] stored_card;
        logic [3:0]  attempt_limit;
        logic [15:0] lockout_length;
        logic [15:0] open_length;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  key_code;
        logic [39:0] card_id;
    } item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic        relay_open;
        logic        locked_out;
        logic [3:0]  failures;
        logic [2:0]  digits_held;
        logic        code_ok;
        logic        card_ok;
        logic [15:0] ticks_left;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/pin_and_card_access_controller_core.sv
// top level of the pin and card access controller core
// depends on pacac_pkg, pacac_cfg, pacac_fsm, pacac_out_reg and assert_macros.svh
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser op, tdata key_code and card_id
// m_*       out  m_tvalid/m_tready   tuser event_res, tdata status fields
// cfg_*     in   cfg_we              cfg_index, cfg_wdata
//
// one item per cycle while results are not stalled; the result register follows the input register
// the step runs between the input register and the result register
// a stalled result holds the step; one more item waits in the input register
// reset clears all lock state and loads the register defaults
`default_nettype none

`include "assert_macros.svh"

module pin_and_card_access_controller_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // key_code[3:0], card_id[43:4], zero fill
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // relay_open[0], locked_out[1], failures[5:2],
                                        // digits_held[8:6], code_ok[9], card_ok[10],
                                        // ticks_left[26:11], zero fill
    output logic [3:0]       m_tuser,   // event_res[3:0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [39:0] cfg_wdata
);

    logic             in_valid_reg;
    logic             in_valid_next;
    pacac_pkg::item_t in_item_reg;
    logic             advance;
    pacac_pkg::cfg_t  cfg;
    pacac_pkg::res_t  res;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op       <= s_tuser;
            in_item_reg.key_code <= s_tdata[3:0];
            in_item_reg.card_id  <= s_tdata[43:4];
        end
    end

    pacac_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pacac_fsm u_fsm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    pacac_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `PAC_NEVER(a_open_and_locked, m_tvalid && m_tdata[0] && m_tdata[1], "relay open during lockout")
    `PAC_ASSERT(a_idle_no_ticks, (m_tvalid && !m_tdata[0] && !m_tdata[1]) |-> (m_tdata[26:11] == 16'd0), "ticks left while idle")
    `PAC_ASSERT(a_digits_bound, m_tvalid |-> (m_tdata[8:6] <= 3'(pacac_pkg::CODE_DIGITS)), "entry holds too many digits")
    `PAC_ASSERT(a_stall_holds_input, (in_valid_reg && !advance) |=> in_valid_reg, "pending item lost during stall")

endmodule

`default_nettype wire

FILE: rtl/core/pacac_cfg.sv
// configuration register bank of the access controller core
// depends on pacac_pkg
`default_nettype none

module pacac_cfg
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [39:0]         cfg_wdata,
    output pacac_pkg::cfg_t          cfg
);

    pacac_pkg::cfg_t cfg_reg;
    pacac_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pacac_pkg::REG_STORED_CODE:    cfg_next.stored_code    = cfg_wdata[15:0];
                pacac_pkg::REG_STORED_CARD:    cfg_next.stored_card    = cfg_wdata;
                pacac_pkg::REG_ATTEMPT_LIMIT:  cfg_next.attempt_limit  = cfg_wdata[3:0];
                pacac_pkg::REG_LOCKOUT_LENGTH: cfg_next.lockout_length = cfg_wdata[15:0];
                pacac_pkg::REG_OPEN_LENGTH:    cfg_next.open_length    = cfg_wdata[15:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stored_code    <= pacac_pkg::RST_STORED_CODE;
            cfg_reg.stored_card    <= pacac_pkg::RST_STORED_CARD;
            cfg_reg.attempt_limit  <= pacac_pkg::RST_ATTEMPT_LIMIT;
            cfg_reg.lockout_length <= pacac_pkg::RST_LOCKOUT_LENGTH;
            cfg_reg.open_length    <= pacac_pkg::RST_OPEN_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pacac_fsm.sv
// lock state registers and the single-pass step logic for one item
// depends on pacac_pkg
`default_nettype none

module pacac_fsm
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire pacac_pkg::item_t    item,
    input  wire pacac_pkg::cfg_t     cfg,
    output pacac_pkg::res_t          res
);

    logic [3:0]                  digits_reg [pacac_pkg::CODE_DIGITS];
    logic [3:0]                  digits_next [pacac_pkg::CODE_DIGITS];
    logic [pacac_pkg::CNT_W-1:0] count_reg;
    logic [pacac_pkg::CNT_W-1:0] count_next;
    logic                        code_flag_reg;
    logic                        code_flag_next;
    logic                        card_flag_reg;
    logic                        card_flag_next;
    logic [3:0]                  fail_reg;
    logic [3:0]                  fail_next;
    logic [1:0]                  mode_reg;
    logic [1:0]                  mode_next;
    logic [15:0]                 timer_reg;
    logic [15:0]                 timer_next;

    logic [3:0]  ev;
    logic [3:0]  fail_inc;
    logic        code_match;
    logic [31:0] code_ext;
    logic        fail_locks;

    assign code_ext   = {16'h0000, cfg.stored_code};
    assign fail_inc   = (fail_reg != pacac_pkg::FAIL_MAX) ? fail_reg + 4'd1 : fail_reg;
    assign fail_locks = (fail_inc >= cfg.attempt_limit);

    always_comb
    begin
        code_match = (count_reg == pacac_pkg::CNT_W'(pacac_pkg::CODE_DIGITS));
        for (int i = 0; i < pacac_pkg::CODE_DIGITS; i++)
        begin
            if (digits_reg[i] != code_ext[4*(pacac_pkg::CODE_DIGITS-1-i) +: 4])
            begin
                code_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        digits_next    = digits_reg;
        count_next     = count_reg;
        code_flag_next = code_flag_reg;
        card_flag_next = card_flag_reg;
        fail_next      = fail_reg;
        mode_next      = mode_reg;
        timer_next     = timer_reg;
        ev             = pacac_pkg::EV_NONE;

        case (item.op)
            pacac_pkg::OP_TICK:
            begin
                if (mode_reg != pacac_pkg::MODE_IDLE)
                begin
                    if (timer_reg > 16'd1)
                    begin
                        timer_next = timer_reg - 16'd1;
                    end
                    else
                    begin
                        timer_next = 16'd0;
                        mode_next  = pacac_pkg::MODE_IDLE;
                        if (mode_reg == pacac_pkg::MODE_OPEN)
                        begin
                            code_flag_next = 1'b0;
                            card_flag_next = 1'b0;
                            count_next     = '0;
                            for (int i = 0; i < pacac_pkg::CODE_DIGITS; i++)
                            begin
                                digits_next[i] = 4'd0;
                            end
                            ev = pacac_pkg::EV_RELOCKED;
                        end
                        else
                        begin
                            fail_next = 4'd0;
                            ev        = pacac_pkg::EV_LOCK_END;
                        end
                    end
                end
            end
            pacac_pkg::OP_KEY:
            begin
                if (mode_reg != pacac_pkg::MODE_IDLE)
                begin
                    ev = pacac_pkg::EV_IGNORED;
                end
                else if (item.key_code <= pacac_pkg::KEY_DIGIT_MAX)
                begin
                    if (count_reg < pacac_pkg::CNT_W'(pacac_pkg::CODE_DIGITS))
                    begin
                        for (int i = 0; i < pacac_pkg::CODE_DIGITS; i++)
                        begin
                            if (count_reg == pacac_pkg::CNT_W'(i))
                            begin
                                digits_next[i] = item.key_code;
                            end
                        end
                        count_next = count_reg + pacac_pkg::CNT_W'(1);
                        ev         = pacac_pkg::EV_DIGIT;
                    end
                    else
                    begin
                        ev = pacac_pkg::EV_IGNORED;
                    end
                end
                else if (item.key_code == pacac_pkg::KEY_STAR || item.key_code == pacac_pkg::KEY_HASH)
                begin
                    count_next = '0;
                    for (int i = 0; i < pacac_pkg::CODE_DIGITS; i++)
                    begin
                        digits_next[i] = 4'd0;
                    end
                    if (item.key_code == pacac_pkg::KEY_STAR)
                    begin
                        ev = pacac_pkg::EV_CLEARED;
                    end
                    else if (code_match)
                    begin
                        code_flag_next = 1'b1;
                        if (card_flag_reg)
                        begin
                            mode_next  = pacac_pkg::MODE_OPEN;
                            timer_next = cfg.open_length;
                            ev         = pacac_pkg::EV_GRANTED;
                        end
                        else
                        begin
                            ev = pacac_pkg::EV_CODE_OK;
                        end
                    end
                    else
                    begin
                        code_flag_next = 1'b0;
                        fail_next      = fail_inc;
                        if (fail_locks)
                        begin
                            mode_next  = pacac_pkg::MODE_LOCK;
                            timer_next = cfg.lockout_length;
                            ev         = pacac_pkg::EV_LOCK_START;
                        end
                        else
                        begin
                            ev = pacac_pkg::EV_CODE_BAD;
                        end
                    end
                end
                else
                begin
                    ev = pacac_pkg::EV_IGNORED;
                end
            end
            pacac_pkg::OP_CARD:
            begin
                if (mode_reg != pacac_pkg::MODE_IDLE)
                begin
                    ev = pacac_pkg::EV_IGNORED;
                end
                else if (item.card_id == cfg.stored_card)
                begin
                    card_flag_next = 1'b1;
                    if (code_flag_reg)
                    begin
                        mode_next  = pacac_pkg::MODE_OPEN;
                        timer_next = cfg.open_length;
                        ev         = pacac_pkg::EV_GRANTED;
                    end
                    else
                    begin
                        ev = pacac_pkg::EV_CARD_OK;
                    end
                end
                else
                begin
                    card_flag_next = 1'b0;
                    fail_next      = fail_inc;
                    if (fail_locks)
                    begin
                        mode_next  = pacac_pkg::MODE_LOCK;
                        timer_next = cfg.lockout_length;
                        ev         = pacac_pkg::EV_LOCK_START;
                    end
                    else
                    begin
                        ev = pacac_pkg::EV_CARD_BAD;
                    end
                end
            end
            default:
            begin
                ev = pacac_pkg::EV_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pacac_pkg::CODE_DIGITS; i++)
            begin
                digits_reg[i] <= 4'd0;
            end
            count_reg     <= '0;
            code_flag_reg <= 1'b0;
            card_flag_reg <= 1'b0;
            fail_reg      <= 4'd0;
            mode_reg      <= pacac_pkg::MODE_IDLE;
            timer_reg     <= 16'd0;
        end
        else if (en)
        begin
            digits_reg    <= digits_next;
            count_reg     <= count_next;
            code_flag_reg <= code_flag_next;
            card_flag_reg <= card_flag_next;
            fail_reg      <= fail_next;
            mode_reg      <= mode_next;
            timer_reg     <= timer_next;
        end
    end

    always_comb
    begin
        res.event_res   = ev;
        res.relay_open  = (mode_next == pacac_pkg::MODE_OPEN);
        res.locked_out  = (mode_next == pacac_pkg::MODE_LOCK);
        res.failures    = fail_next;
        res.digits_held = 3'(count_next);
        res.code_ok     = code_flag_next;
        res.card_ok     = card_flag_next;
        res.ticks_left  = (mode_next != pacac_pkg::MODE_IDLE) ? timer_next : 16'd0;
    end

endmodule

`default_nettype wire

FILE: rtl/core/pacac_out_reg.sv
// result register on the master side, holds a result until its transfer
// depends on pacac_pkg
`default_nettype none

module pacac_out_reg
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire pacac_pkg::res_t     res,
    input  wire logic                m_tready,
    output logic                     m_tvalid,
    output logic [31:0]              m_tdata,
    output logic [3:0]               m_tuser
);

    logic            valid_reg;
    logic            valid_next;
    pacac_pkg::res_t res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {5'd0, res_reg.ticks_left, res_reg.card_ok, res_reg.code_ok,
                       res_reg.digits_held, res_reg.failures, res_reg.locked_out,
                       res_reg.relay_open};

endmodule

`default_nettype wire
